[rtl/bitmap_frame_allocator_defines.svh]
// assertion macros shared by the checker
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while in reset
`define BFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa same-cycle check failed");

// next-cycle implication, off while in reset
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfa next-cycle check failed");

// next-cycle implication that also holds through reset
`define BFA_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfa reset check failed");

`endif

[rtl/bfa_pkg.sv]
package bfa_pkg;

    localparam int FR_W  = 13;
    localparam int RUN_W = 14;
    localparam int POP_W = 7;

    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    localparam logic [FR_W-1:0] CNT_MAX   = 13'h1FFF;
    localparam logic [FR_W-1:0] LIMIT_RST = 13'd4096;

    typedef enum logic [2:0] {
        ACT_MAKE  = 3'd0,
        ACT_MARK  = 3'd1,
        ACT_ALLOC = 3'd2,
        ACT_RUN   = 3'd3,
        ACT_BELOW = 3'd4,
        ACT_FREE  = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        KIND_CLR,
        KIND_SET,
        KIND_FIND,
        KIND_RUN,
        KIND_FILL
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [FR_W-1:0]   lo;
        logic [FR_W-1:0]   hi;
        logic [FR_W-1:0]   count;
        logic [RUN_W-1:0]  run_in;
        logic [FR_W-1:0]   start_in;
        logic [FR_W-1:0]   base;
    } wu_ctl_t;

    typedef struct packed {
        logic [POP_W-1:0]  n_bits;
        logic              found;
        logic [FR_W-1:0]   find_frame;
        logic              run_hit;
        logic [FR_W-1:0]   run_first;
        logic [RUN_W-1:0]  run_out;
        logic [FR_W-1:0]   start_out;
    } wu_res_t;

    function automatic logic [FR_W-1:0] sat_add(input logic [FR_W-1:0] a,
                                                 input logic [RUN_W-1:0] b);
        logic [RUN_W-1:0] sum;
        sum = {1'b0, a} + b;
        return (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[FR_W-1:0];
    endfunction

endpackage

[rtl/bitmap_frame_allocator.sv]
// first-fit page frame allocator over an occupancy bitmap held in one ram,
// one word of WORD_BITS frames per entry, bit set meaning occupied.
// s_ channel: one item per request, action in s_tuser; m_ channel: one item
// per request, success flag in m_tuser. cfg_wr_en/cfg_wr_data write frame_limit.
// after reset a clearing pass writes every ram word to all ones; s_tready stays
// low meanwhile.
// an item is taken when the block is idle; the sequencer reads one word per
// cycle through the single ram read port and writes it back modified, except
// that a run search only reads and a first-fit search writes only its hit word.
// after accept the sequencer goes through issue, a scan step per word visited and
// done, where the result is loaded; only then does it return to idle for the next
// item. range actions visit the words of the range; allocations scan from word 0
// until a hit, up to MAP_WORDS words (64 at the defaults); a run allocation adds
// a fill pass through issue and the words the run spans. immediate cases go from
// accept straight to the done state.
// a finished result sits in the output register; a new item is accepted
// while it waits, and the next result waits in the done state until the
// receiver takes the previous one.
module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // frame_number[11:0], count[24:12], limit_frame[37:25]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // frame[11:0], used_count[24:12], free_count[37:25]
    output logic        m_tuser,   // success[0]
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data
);

    localparam int FR_W      = bfa_pkg::FR_W;
    localparam int RUN_W     = bfa_pkg::RUN_W;
    localparam int LW        = $clog2(WORD_BITS);
    localparam int WI        = FR_W - LW;
    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [FR_W-1:0] LIM_CAP = FR_W'((NUM_FRAMES < 8191) ? NUM_FRAMES : 8191);

    bfa_pkg::state_t  state_reg, state_next;
    bfa_pkg::kind_t   kind_reg, kind_next;
    logic             free_reg, free_next;
    logic [FR_W-1:0]  lo_reg, lo_next;
    logic [FR_W-1:0]  hi_reg, hi_next;
    logic [FR_W-1:0]  cnt_reg, cnt_next;
    logic [WI-1:0]    w_reg, w_next;
    logic [WI-1:0]    wlast_reg, wlast_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [FR_W-1:0]  start_reg, start_next;
    logic [FR_W-1:0]  frame_reg, frame_next;
    logic             ok_reg, ok_next;
    logic [FR_W-1:0]  used_reg, used_next;
    logic [FR_W-1:0]  managed_reg, managed_next;
    logic [FR_W-1:0]  limit_reg;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    logic [11:0]      m_frame_reg, m_frame_next;
    logic             m_ok_reg, m_ok_next;
    logic [FR_W-1:0]  m_used_reg, m_used_next;
    logic [FR_W-1:0]  m_free_reg, m_free_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] wu_word;
    bfa_pkg::wu_ctl_t     wu_ctl;
    bfa_pkg::wu_res_t     wu_res;

    logic [11:0]       in_first;
    logic [FR_W-1:0]   in_count;
    logic [FR_W-1:0]   in_below;
    bfa_pkg::act_t     in_act;
    logic [FR_W-1:0]   lim;
    logic [RUN_W-1:0]  sum_w;
    logic [FR_W-1:0]   rng_lo;
    logic [FR_W-1:0]   rng_hi;
    logic [FR_W-1:0]   rng_hi_m1;
    logic [FR_W-1:0]   bnd;
    logic [FR_W-1:0]   bnd_m1;
    logic [FR_W-1:0]   lim_m1;
    logic [FR_W-1:0]   fill_hi;
    logic [FR_W-1:0]   fill_hi_m1;
    logic              last_word;

    assign in_first = s_tdata[11:0];
    assign in_count = s_tdata[24:12];
    assign in_below = s_tdata[37:25];
    assign in_act   = bfa_pkg::act_t'(s_tuser);

    assign lim        = (limit_reg < LIM_CAP) ? limit_reg : LIM_CAP;
    assign lim_m1     = lim - 1'b1;
    assign sum_w      = RUN_W'(in_first) + RUN_W'(in_count);
    assign rng_hi     = (sum_w < RUN_W'(lim)) ? sum_w[FR_W-1:0] : lim;
    assign rng_lo     = (in_first == '0) ? FR_W'(1) : FR_W'(in_first);
    assign rng_hi_m1  = rng_hi - 1'b1;
    assign bnd        = (in_act == bfa_pkg::ACT_BELOW && in_below < lim) ? in_below : lim;
    assign bnd_m1     = bnd - 1'b1;
    assign fill_hi    = wu_res.run_first + cnt_reg;
    assign fill_hi_m1 = fill_hi - 1'b1;
    assign last_word  = (w_reg == wlast_reg);

    assign wu_ctl.kind     = kind_reg;
    assign wu_ctl.lo       = lo_reg;
    assign wu_ctl.hi       = hi_reg;
    assign wu_ctl.count    = cnt_reg;
    assign wu_ctl.run_in   = run_reg;
    assign wu_ctl.start_in = start_reg;
    assign wu_ctl.base     = {w_reg, {LW{1'b0}}};

    bfa_map_ram #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (MAP_WORDS),
        .AW        (AW)
    ) u_map_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word_unit (
        .ctl     (wu_ctl),
        .rd_word (ram_rdata),
        .wr_word (wu_word),
        .res     (wu_res)
    );

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        free_next    = free_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        w_next       = w_reg;
        wlast_next   = wlast_reg;
        run_next     = run_reg;
        start_next   = start_reg;
        frame_next   = frame_reg;
        ok_next      = ok_reg;
        used_next    = used_reg;
        managed_next = managed_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_frame_next = m_frame_reg;
        m_ok_next    = m_ok_reg;
        m_used_next  = m_used_reg;
        m_free_next  = m_free_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(w_reg);
        ram_wdata    = wu_word;
        ram_re       = 1'b0;
        ram_raddr    = AW'(w_reg);
        s_tready     = 1'b0;

        unique case (state_reg)
            bfa_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                if (clr_reg == AW'(MAP_WORDS - 1)) begin
                    state_next = bfa_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            bfa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    frame_next = '0;
                    ok_next    = 1'b1;
                    run_next   = '0;
                    start_next = '0;
                    cnt_next   = in_count;
                    free_next  = (in_act == bfa_pkg::ACT_FREE);
                    state_next = bfa_pkg::ST_DONE;
                    unique case (in_act) inside
                        bfa_pkg::ACT_MAKE, bfa_pkg::ACT_FREE: begin
                            kind_next  = bfa_pkg::KIND_CLR;
                            lo_next    = rng_lo;
                            hi_next    = rng_hi;
                            w_next     = rng_lo[FR_W-1:LW];
                            wlast_next = rng_hi_m1[FR_W-1:LW];
                            if (rng_lo < rng_hi) begin
                                state_next = bfa_pkg::ST_ISSUE;
                            end
                        end
                        bfa_pkg::ACT_MARK: begin
                            kind_next  = bfa_pkg::KIND_SET;
                            lo_next    = FR_W'(in_first);
                            hi_next    = FR_W'(in_first) + 1'b1;
                            w_next     = WI'(in_first[11:LW]);
                            wlast_next = WI'(in_first[11:LW]);
                            if (FR_W'(in_first) < lim) begin
                                state_next = bfa_pkg::ST_ISSUE;
                            end
                        end
                        bfa_pkg::ACT_ALLOC, bfa_pkg::ACT_BELOW, bfa_pkg::ACT_RUN: begin
                            lo_next = '0;
                            w_next  = '0;
                            if (in_act == bfa_pkg::ACT_RUN && in_count == '0) begin
                                ok_next = 1'b0;
                            end else if (in_act == bfa_pkg::ACT_RUN && in_count != 13'd1) begin
                                kind_next  = bfa_pkg::KIND_RUN;
                                hi_next    = lim;
                                wlast_next = lim_m1[FR_W-1:LW];
                                if (lim == '0) begin
                                    ok_next = 1'b0;
                                end else begin
                                    state_next = bfa_pkg::ST_ISSUE;
                                end
                            end else begin
                                kind_next  = bfa_pkg::KIND_FIND;
                                hi_next    = bnd;
                                wlast_next = bnd_m1[FR_W-1:LW];
                                if (bnd == '0) begin
                                    ok_next = 1'b0;
                                end else begin
                                    state_next = bfa_pkg::ST_ISSUE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bfa_pkg::ST_ISSUE: begin
                ram_re     = 1'b1;
                state_next = bfa_pkg::ST_SCAN;
            end
            bfa_pkg::ST_SCAN: begin
                // read one word ahead while the current one is checked or written back
                ram_re    = 1'b1;
                ram_raddr = AW'(w_reg + 1'b1);
                w_next    = w_reg + 1'b1;
                case (kind_reg)
                    bfa_pkg::KIND_FIND: begin
                        if (wu_res.found) begin
                            ram_we     = 1'b1;
                            used_next  = bfa_pkg::sat_add(used_reg, RUN_W'(1));
                            frame_next = wu_res.find_frame;
                            state_next = bfa_pkg::ST_DONE;
                        end else if (last_word) begin
                            ok_next    = 1'b0;
                            state_next = bfa_pkg::ST_DONE;
                        end
                    end
                    bfa_pkg::KIND_RUN: begin
                        run_next   = wu_res.run_out;
                        start_next = wu_res.start_out;
                        if (wu_res.run_hit) begin
                            // run found, go back and mark it in a fill pass
                            kind_next  = bfa_pkg::KIND_FILL;
                            lo_next    = wu_res.run_first;
                            hi_next    = fill_hi;
                            w_next     = wu_res.run_first[FR_W-1:LW];
                            wlast_next = fill_hi_m1[FR_W-1:LW];
                            used_next  = bfa_pkg::sat_add(used_reg, RUN_W'(cnt_reg));
                            frame_next = wu_res.run_first;
                            state_next = bfa_pkg::ST_ISSUE;
                        end else if (last_word) begin
                            ok_next    = 1'b0;
                            state_next = bfa_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        ram_we = 1'b1;
                        if (kind_reg == bfa_pkg::KIND_SET) begin
                            used_next = bfa_pkg::sat_add(used_reg, RUN_W'(wu_res.n_bits));
                        end else if (kind_reg == bfa_pkg::KIND_CLR) begin
                            if (free_reg) begin
                                used_next = (used_reg > FR_W'(wu_res.n_bits)) ?
                                            used_reg - FR_W'(wu_res.n_bits) : '0;
                            end else begin
                                managed_next = bfa_pkg::sat_add(managed_reg,
                                                                RUN_W'(wu_res.n_bits));
                            end
                        end
                        if (last_word) begin
                            state_next = bfa_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            bfa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_frame_next = ok_reg ? frame_reg[11:0] : 12'd0;
                    m_ok_next    = ok_reg;
                    m_used_next  = used_reg;
                    m_free_next  = (managed_reg > used_reg) ? managed_reg - used_reg : '0;
                    state_next   = bfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfa_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            managed_reg <= '0;
            limit_reg   <= bfa_pkg::LIMIT_RST;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            used_reg    <= used_next;
            managed_reg <= managed_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        free_reg    <= free_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        cnt_reg     <= cnt_next;
        w_reg       <= w_next;
        wlast_reg   <= wlast_next;
        run_reg     <= run_next;
        start_reg   <= start_next;
        frame_reg   <= frame_next;
        ok_reg      <= ok_next;
        m_frame_reg <= m_frame_next;
        m_ok_reg    <= m_ok_next;
        m_used_reg  <= m_used_next;
        m_free_reg  <= m_free_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {2'b00, m_free_reg, m_used_reg, m_frame_reg};

endmodule

[rtl/bfa_map_ram.sv]
module bfa_map_ram #(
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF,
    parameter int DEPTH     = 64,
    parameter int AW        = 6
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/bfa_word_unit.sv]
module bfa_word_unit #(
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
    input  bfa_pkg::wu_ctl_t      ctl,
    input  logic [WORD_BITS-1:0]  rd_word,
    output logic [WORD_BITS-1:0]  wr_word,
    output bfa_pkg::wu_res_t      res
);

    localparam int LW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0]      inr;
    logic [WORD_BITS-1:0]      mask;
    logic [WORD_BITS-1:0]      free_b;
    logic [WORD_BITS-1:0]      occ;
    logic [WORD_BITS-1:0]      hit;
    logic                      has  [WORD_BITS];
    logic [LW-1:0]             last [WORD_BITS];
    logic [bfa_pkg::RUN_W-1:0] runlen [WORD_BITS];
    logic [LW-1:0]             pos;
    logic [LW-1:0]             hp;
    logic [bfa_pkg::POP_W-1:0] pop;

    // bits of this word inside [lo, hi)
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            inr[j] = ((ctl.base + bfa_pkg::FR_W'(j)) >= ctl.lo) &&
                     ((ctl.base + bfa_pkg::FR_W'(j)) < ctl.hi);
        end
    end

    always_comb begin
        free_b = ~rd_word & inr;
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_b[j]) begin
                pos = LW'(j);
            end
        end
    end

    // position of the nearest occupied bit at or below each bit, prefix style
    always_comb begin
        occ = rd_word | ~inr;
        for (int j = 0; j < WORD_BITS; j++) begin
            has[j]  = occ[j];
            last[j] = LW'(j);
        end
        for (int s = 1; s < WORD_BITS; s = s * 2) begin
            for (int j = WORD_BITS - 1; j >= s; j--) begin
                if (!has[j]) begin
                    has[j]  = has[j-s];
                    last[j] = last[j-s];
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++) begin
            if (has[j]) begin
                runlen[j] = bfa_pkg::RUN_W'(j) - bfa_pkg::RUN_W'(last[j]);
            end else begin
                runlen[j] = ctl.run_in + bfa_pkg::RUN_W'(j) + 1'b1;
            end
            hit[j] = !occ[j] && (runlen[j] >= {1'b0, ctl.count});
        end
        hp = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hp = LW'(j);
            end
        end
    end

    always_comb begin
        case (ctl.kind)
            bfa_pkg::KIND_CLR: begin
                mask    = rd_word & inr;
                wr_word = rd_word & ~mask;
            end
            bfa_pkg::KIND_SET: begin
                mask    = ~rd_word & inr;
                wr_word = rd_word | mask;
            end
            bfa_pkg::KIND_FILL: begin
                mask    = inr;
                wr_word = rd_word | inr;
            end
            bfa_pkg::KIND_FIND: begin
                mask    = '0;
                wr_word = rd_word |
                          ((|free_b) ? (WORD_BITS'(1) << pos) : WORD_BITS'(0));
            end
            default: begin
                mask    = '0;
                wr_word = rd_word;
            end
        endcase
    end

    always_comb begin
        pop = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            pop = pop + bfa_pkg::POP_W'(mask[j]);
        end
    end

    always_comb begin
        res.n_bits     = pop;
        res.found      = |free_b;
        res.find_frame = ctl.base + bfa_pkg::FR_W'(pos);
        res.run_hit    = |hit;
        if (has[hp]) begin
            res.run_first = ctl.base + bfa_pkg::FR_W'(last[hp]) + 1'b1;
        end else begin
            res.run_first = (ctl.run_in == '0) ? ctl.base : ctl.start_in;
        end
        res.run_out = runlen[WORD_BITS-1];
        if (has[WORD_BITS-1]) begin
            res.start_out = ctl.base + bfa_pkg::FR_W'(last[WORD_BITS-1]) + 1'b1;
        end else begin
            res.start_out = (ctl.run_in == '0) ? ctl.base : ctl.start_in;
        end
    end

endmodule

[rtl/bfa_checker.sv]
`include "bitmap_frame_allocator_defines.svh"

module bfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // reset leaves the input closed and the output empty
    `BFA_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid && !s_tready)

    // one item in flight: no second accept right after the first
    `BFA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // a failed allocation reports frame zero
    `BFA_ASSERT_NOW(a_fail_frame_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[11:0] == 12'd0)

    `BFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
